@@ hdl/pr2_pkg.sv @@
// Shared types, constants and the micro-op program of the squared-correlation block.
`default_nettype none

package pr2_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM1_W      = 29;
  localparam int SUM2_W      = 43;
  localparam int LIMB_W      = 28;
  localparam int PROD_W      = 2 * LIMB_W;
  localparam int MAG_W       = 2 * LIMB_W;
  localparam int OPV_W       = MAG_W + 1;
  localparam int WIDE_W      = 2 * MAG_W;
  localparam int ACC_W       = WIDE_W + 1;
  localparam int Q_W         = 17;
  localparam int STEP_W      = 5;
  localparam int DIV_STEPS   = 17;
  localparam int DIVC_W      = $clog2(DIV_STEPS);

  localparam logic [Q_W-1:0]    ONE_Q16          = Q_W'(65536);
  localparam logic [STEP_W-1:0] STEP_SAMPLE_LAST = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_FINAL_FIRST = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_VY          = STEP_W'(11);
  localparam logic [STEP_W-1:0] STEP_LAST        = STEP_W'(19);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] y_value;
    logic                       last;
  } pr2_in_t;

  typedef struct packed {
    logic [Q_W-1:0] r_squared;
    logic           constant_series;
    logic           too_many;
  } pr2_out_t;

  typedef enum logic [3:0] {
    SRC_X, SRC_Y, SRC_N, SRC_SX, SRC_SY, SRC_SXY, SRC_SXX, SRC_SYY,
    SRC_COV, SRC_VX, SRC_VY
  } src_t;

  typedef enum logic [3:0] {
    DST_ACC, DST_SXY, DST_SXX, DST_SYY, DST_COV, DST_VX, DST_VY, DST_NUM, DST_DEN
  } dst_t;

  typedef enum logic [1:0] {
    SH_0, SH_1, SH_2
  } shift_t;

  typedef struct packed {
    src_t   src_a;
    logic   limb_a;
    src_t   src_b;
    logic   limb_b;
    shift_t shift;
    logic   neg;
    dst_t   dst;
  } upop_t;

  typedef struct packed {
    logic              en;
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
    shift_t            shift;
    logic              neg;
  } mul_req_t;

  function automatic upop_t mk(src_t sa, logic la, src_t sb, logic lb, shift_t sh,
                               logic ng, dst_t d);
    upop_t o;
    o.src_a  = sa;
    o.limb_a = la;
    o.src_b  = sb;
    o.limb_b = lb;
    o.shift  = sh;
    o.neg    = ng;
    o.dst    = d;
    return o;
  endfunction

  // Program: three per-sample products, then cov, vx, vy, cov^2 and vx*vy.
  function automatic upop_t pr2_upop(logic [STEP_W-1:0] step);
    upop_t o;
    unique case (step)
      5'd0:    o = mk(SRC_X,   1'b0, SRC_Y,   1'b0, SH_0, 1'b0, DST_SXY);
      5'd1:    o = mk(SRC_X,   1'b0, SRC_X,   1'b0, SH_0, 1'b0, DST_SXX);
      5'd2:    o = mk(SRC_Y,   1'b0, SRC_Y,   1'b0, SH_0, 1'b0, DST_SYY);
      5'd3:    o = mk(SRC_N,   1'b0, SRC_SXY, 1'b0, SH_0, 1'b0, DST_ACC);
      5'd4:    o = mk(SRC_N,   1'b0, SRC_SXY, 1'b1, SH_1, 1'b0, DST_ACC);
      5'd5:    o = mk(SRC_SX,  1'b0, SRC_SY,  1'b0, SH_0, 1'b1, DST_COV);
      5'd6:    o = mk(SRC_N,   1'b0, SRC_SXX, 1'b0, SH_0, 1'b0, DST_ACC);
      5'd7:    o = mk(SRC_N,   1'b0, SRC_SXX, 1'b1, SH_1, 1'b0, DST_ACC);
      5'd8:    o = mk(SRC_SX,  1'b0, SRC_SX,  1'b0, SH_0, 1'b1, DST_VX);
      5'd9:    o = mk(SRC_N,   1'b0, SRC_SYY, 1'b0, SH_0, 1'b0, DST_ACC);
      5'd10:   o = mk(SRC_N,   1'b0, SRC_SYY, 1'b1, SH_1, 1'b0, DST_ACC);
      5'd11:   o = mk(SRC_SY,  1'b0, SRC_SY,  1'b0, SH_0, 1'b1, DST_VY);
      5'd12:   o = mk(SRC_COV, 1'b0, SRC_COV, 1'b0, SH_0, 1'b0, DST_ACC);
      5'd13:   o = mk(SRC_COV, 1'b0, SRC_COV, 1'b1, SH_1, 1'b0, DST_ACC);
      5'd14:   o = mk(SRC_COV, 1'b1, SRC_COV, 1'b0, SH_1, 1'b0, DST_ACC);
      5'd15:   o = mk(SRC_COV, 1'b1, SRC_COV, 1'b1, SH_2, 1'b0, DST_NUM);
      5'd16:   o = mk(SRC_VX,  1'b0, SRC_VY,  1'b0, SH_0, 1'b0, DST_ACC);
      5'd17:   o = mk(SRC_VX,  1'b0, SRC_VY,  1'b1, SH_1, 1'b0, DST_ACC);
      5'd18:   o = mk(SRC_VX,  1'b1, SRC_VY,  1'b0, SH_1, 1'b0, DST_ACC);
      5'd19:   o = mk(SRC_VX,  1'b1, SRC_VY,  1'b1, SH_2, 1'b0, DST_DEN);
      default: o = mk(SRC_N,   1'b0, SRC_N,   1'b0, SH_0, 1'b0, DST_ACC);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

@@ hdl/pearson_r_squared_core.sv @@
// Top level: squared Pearson correlation of paired samples, one shared multiplier and adder.
//
//  channel | ports                     | transfer
//  --------+---------------------------+-------------------------------------------
//  input   | start, busy, in_data      | edge with start high and busy low
//  result  | out_valid, out_data       | edge ending the single cycle out_valid is high
//
// Sequence: a kept, non-last pair takes its transfer plus three multiply/add pairs of the
// shared limb multiplier. A last pair adds seventeen multiply/add micro-ops, seventeen steps
// of restoring division on the shared 113-bit adder and the result; when a series
// is constant it stops after the vy micro-op and goes to the result. A pair beyond the
// sample limit is dropped in its transfer cycle. Reset is synchronous and clears all sums
// and control. The receiver cannot stall; the result is shown for one cycle only.
`default_nettype none

module pearson_r_squared_core import pr2_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pr2_in_t  in_data,
  output logic     out_valid,
  output pr2_out_t out_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIVC_W-1:0] divc_r, divc_nxt;
  logic              last_r, last_nxt;
  logic              ovf_r, ovf_nxt;
  logic              flat_r, flat_nxt;

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [SUM1_W-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [SUM2_W-1:0]   sxy_r, sxy_nxt, sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic [MAG_W-1:0]           cov_r, cov_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic [WIDE_W-1:0]          rem_r, rem_nxt, den_r, den_nxt;
  logic [Q_W-1:0]             q_r, q_nxt;

  upop_t                   op;
  mul_req_t                mreq;
  logic signed [ACC_W-1:0] term_r;
  logic signed [OPV_W-1:0] val_a, val_b, abs_a, abs_b;
  logic [ACC_W-1:0]        add_a, add_b, add_sum;
  logic                    add_sub;
  logic signed [ACC_W-1:0] sum_abs;
  logic                    accept, div_ok;

  function automatic logic signed [OPV_W-1:0] pick(src_t s);
    logic signed [OPV_W-1:0] v;
    unique case (s)
      SRC_X:   v = OPV_W'(x_r);
      SRC_Y:   v = OPV_W'(y_r);
      SRC_N:   v = $signed({{(OPV_W-CNT_W){1'b0}}, cnt_r});
      SRC_SX:  v = OPV_W'(sx_r);
      SRC_SY:  v = OPV_W'(sy_r);
      SRC_SXY: v = OPV_W'(sxy_r);
      SRC_SXX: v = OPV_W'(sxx_r);
      SRC_SYY: v = OPV_W'(syy_r);
      SRC_COV: v = $signed({1'b0, cov_r});
      SRC_VX:  v = $signed({1'b0, vx_r});
      SRC_VY:  v = $signed({1'b0, vy_r});
      default: v = '0;
    endcase
    return v;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign op     = pr2_upop(step_r);

  // operand fetch: signed operands go in as magnitude limbs, sign folds into neg
  always_comb begin
    val_a      = pick(op.src_a);
    val_b      = pick(op.src_b);
    abs_a      = val_a[OPV_W-1] ? -val_a : val_a;
    abs_b      = val_b[OPV_W-1] ? -val_b : val_b;
    mreq.en    = (state_r == ST_MUL);
    mreq.a     = op.limb_a ? abs_a[MAG_W-1:LIMB_W] : abs_a[LIMB_W-1:0];
    mreq.b     = op.limb_b ? abs_b[MAG_W-1:LIMB_W] : abs_b[LIMB_W-1:0];
    mreq.shift = op.shift;
    mreq.neg   = op.neg ^ val_a[OPV_W-1] ^ val_b[OPV_W-1];
  end

  pr2_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .term_r (term_r)
  );

  // shared adder: accumulate in the add phase, trial subtract in division
  always_comb begin
    if (state_r == ST_DIV) begin
      add_a   = (divc_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
      add_b   = {1'b0, den_r};
      add_sub = 1'b1;
    end else begin
      unique case (op.dst)
        DST_SXY: add_a = ACC_W'(sxy_r);
        DST_SXX: add_a = ACC_W'(sxx_r);
        DST_SYY: add_a = ACC_W'(syy_r);
        default: add_a = acc_r;
      endcase
      add_b   = term_r;
      add_sub = 1'b0;
    end
    add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);
    sum_abs = add_sum[ACC_W-1] ? -$signed(add_sum) : $signed(add_sum);
    div_ok  = !add_sum[ACC_W-1];
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    divc_nxt  = divc_r;
    last_nxt  = last_r;
    ovf_nxt   = ovf_r;
    flat_nxt  = flat_r;
    cnt_nxt   = cnt_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sxy_nxt   = sxy_r;
    sxx_nxt   = sxx_r;
    syy_nxt   = syy_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    cov_nxt   = cov_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_data.last;
          x_nxt    = in_data.x_value;
          y_nxt    = in_data.y_value;
          if (cnt_r < CNT_W'(MAX_SAMPLES)) begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            sx_nxt    = sx_r + SUM1_W'(in_data.x_value);
            sy_nxt    = sy_r + SUM1_W'(in_data.y_value);
            step_nxt  = '0;
            state_nxt = ST_MUL;
          end else begin
            // drop the pair, remember the overflow
            ovf_nxt = 1'b1;
            if (in_data.last) begin
              step_nxt  = STEP_FINAL_FIRST;
              state_nxt = ST_MUL;
            end
          end
        end
      end

      ST_MUL: begin
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        unique case (op.dst)
          DST_SXY: sxy_nxt = add_sum[SUM2_W-1:0];
          DST_SXX: sxx_nxt = add_sum[SUM2_W-1:0];
          DST_SYY: syy_nxt = add_sum[SUM2_W-1:0];
          DST_ACC: acc_nxt = $signed(add_sum);
          DST_COV: begin
            cov_nxt = sum_abs[MAG_W-1:0];
            acc_nxt = '0;
          end
          DST_VX: begin
            vx_nxt  = add_sum[MAG_W-1:0];
            acc_nxt = '0;
          end
          DST_VY: begin
            vy_nxt  = add_sum[MAG_W-1:0];
            acc_nxt = '0;
          end
          DST_NUM: begin
            rem_nxt = add_sum[WIDE_W-1:0];
            acc_nxt = '0;
          end
          DST_DEN: begin
            den_nxt = add_sum[WIDE_W-1:0];
            acc_nxt = '0;
          end
          default: acc_nxt = acc_r;
        endcase

        priority if (step_r == STEP_SAMPLE_LAST && !last_r) begin
          state_nxt = ST_IDLE;
        end else if (step_r == STEP_VY &&
                     (vx_r == '0 || add_sum[MAG_W-1:0] == '0)) begin
          // a constant series: skip the quotient
          flat_nxt  = 1'b1;
          state_nxt = ST_OUT;
        end else if (step_r == STEP_LAST) begin
          divc_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_MUL;
        end
      end

      ST_DIV: begin
        rem_nxt = div_ok ? add_sum[WIDE_W-1:0] : add_a[WIDE_W-1:0];
        q_nxt   = (divc_r == '0) ? Q_W'(div_ok) : {q_r[Q_W-2:0], div_ok};
        if (divc_r == DIVC_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          divc_nxt = divc_r + DIVC_W'(1);
        end
      end

      ST_OUT: begin
        // clear the set for the next series
        cnt_nxt   = '0;
        sx_nxt    = '0;
        sy_nxt    = '0;
        sxy_nxt   = '0;
        sxx_nxt   = '0;
        syy_nxt   = '0;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
        flat_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      divc_r  <= '0;
      last_r  <= 1'b0;
      ovf_r   <= 1'b0;
      flat_r  <= 1'b0;
      cnt_r   <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      divc_r  <= divc_nxt;
      last_r  <= last_nxt;
      ovf_r   <= ovf_nxt;
      flat_r  <= flat_nxt;
      cnt_r   <= cnt_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sxy_r   <= sxy_nxt;
      sxx_r   <= sxx_nxt;
      syy_r   <= syy_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    cov_r <= cov_nxt;
    vx_r  <= vx_nxt;
    vy_r  <= vy_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  // drive the result for the single output cycle; clamp the quotient at one
  assign out_valid = (state_r == ST_OUT);
  always_comb begin
    if (flat_r) begin
      out_data.r_squared = '0;
    end else if (q_r > ONE_Q16) begin
      out_data.r_squared = ONE_Q16;
    end else begin
      out_data.r_squared = q_r;
    end
    out_data.constant_series = flat_r;
    out_data.too_many        = ovf_r;
  end

endmodule

`default_nettype wire

@@ hdl/pr2_mul.sv @@
// Shared limb multiplier: registers a shifted, optionally negated 28x28 product.
`default_nettype none

module pr2_mul import pr2_pkg::*; (
  input  logic                    clk,
  input  mul_req_t                req,
  output logic signed [ACC_W-1:0] term_r
);

  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        shifted;
  logic signed [ACC_W-1:0] term_nxt;

  always_comb begin
    prod = req.a * req.b;
    unique case (req.shift)
      SH_0:    shifted = ACC_W'(prod);
      SH_1:    shifted = ACC_W'(prod) << LIMB_W;
      SH_2:    shifted = ACC_W'(prod) << (2 * LIMB_W);
      default: shifted = '0;
    endcase
    term_nxt = req.neg ? -$signed(shifted) : $signed(shifted);
  end

  // hold the term until the next product is issued
  always_ff @(posedge clk) begin
    if (req.en) begin
      term_r <= term_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pr2_checker.sv @@
// Port-level checker for the squared-correlation block, bound to the top level.
`default_nettype none

module pr2_port_props import pr2_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input pr2_out_t out_data
);

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("input taken while a result is shown");

  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.constant_series) |-> (out_data.r_squared == '0))
    else $error("constant series with non-zero r squared");

  a_r_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.r_squared <= ONE_Q16))
    else $error("r squared above one");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

endmodule

bind pearson_r_squared_core pr2_port_props u_pr2_port_props (.*);

`default_nettype wire
